/* hw/rtl/rhc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

   localparam int ChanWidth       = 8;
   localparam int HueWidth        = 15;
   localparam int PosWidth        = 11;
   localparam int HueDivWidth     = 23;
   localparam int SatDivWidth     = 16;
   localparam int DivSteps        = 15;
   localparam int HueUnitsPerSixth = 3840;
   localparam int FullScale       = 255;

   // one restoring divider lane: partial remainder, then the dividend bits still
   // to come sitting above the quotient bits already produced
   typedef struct packed {
      logic [ChanWidth-1:0] rem;
      logic [DivSteps-1:0]  bits;
      logic [ChanWidth-1:0] divisor;
   } div_lane_type;

   typedef struct packed {
      div_lane_type         hue;
      div_lane_type         sat;
      logic [ChanWidth-1:0] brightness;
   } cell_data_type;

   function automatic div_lane_type div_step(input div_lane_type lane);
      div_lane_type         res;
      logic [ChanWidth:0]   trial;
      logic [ChanWidth:0]   diff;
      logic                 q;
      res   = lane;
      trial = {lane.rem, lane.bits[DivSteps-1]};
      diff  = trial - {1'b0, lane.divisor};
      q     = (trial >= {1'b0, lane.divisor});
      // remainder stays below the divisor, so it always fits in ChanWidth bits
      res.rem  = q ? diff[ChanWidth-1:0] : trial[ChanWidth-1:0];
      res.bits = {lane.bits[DivSteps-2:0], q};
      return res;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/rhc_prep.sv */
`timescale 1ns / 1ps
`default_nettype none

module rhc_prep (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire [rhc_pkg::ChanWidth-1:0] red,
   input  wire [rhc_pkg::ChanWidth-1:0] green,
   input  wire [rhc_pkg::ChanWidth-1:0] blue,
   output logic                        out_valid,
   input  wire                         out_ready,
   output rhc_pkg::cell_data_type      out_data
);

   logic                              valid_ff;
   rhc_pkg::cell_data_type            data_ff;
   rhc_pkg::cell_data_type            data_in;

   logic [rhc_pkg::ChanWidth-1:0]     hi;
   logic [rhc_pkg::ChanWidth-1:0]     lo;
   logic [rhc_pkg::ChanWidth-1:0]     delta;
   logic [rhc_pkg::PosWidth-1:0]      delta_w;
   logic [rhc_pkg::PosWidth-1:0]      pos;
   logic [rhc_pkg::HueDivWidth-1:0]   hue_div;
   logic [rhc_pkg::SatDivWidth-1:0]   sat_div;
   logic                              red_top;
   logic                              green_top;

   always_comb begin
      red_top   = (red >= green) && (red >= blue);
      green_top = !red_top && (green >= blue);
      hi = red_top ? red : (green_top ? green : blue);
      if ((red <= green) && (red <= blue)) begin
         lo = red;
      end else if (green <= blue) begin
         lo = green;
      end else begin
         lo = blue;
      end
      delta   = hi - lo;
      delta_w = rhc_pkg::PosWidth'(delta);

      // position in sixths of a turn, scaled by delta; intermediate wrap is harmless
      if (red_top) begin
         if (green >= blue) begin
            pos = rhc_pkg::PosWidth'(green) - rhc_pkg::PosWidth'(blue);
         end else begin
            pos = delta_w * rhc_pkg::PosWidth'(6)
                  - (rhc_pkg::PosWidth'(blue) - rhc_pkg::PosWidth'(green));
         end
      end else if (green_top) begin
         pos = delta_w * rhc_pkg::PosWidth'(2) + rhc_pkg::PosWidth'(blue)
               - rhc_pkg::PosWidth'(red);
      end else begin
         pos = delta_w * rhc_pkg::PosWidth'(4) + rhc_pkg::PosWidth'(red)
               - rhc_pkg::PosWidth'(green);
      end

      hue_div = rhc_pkg::HueDivWidth'(pos)
                * rhc_pkg::HueDivWidth'(rhc_pkg::HueUnitsPerSixth);
      sat_div = rhc_pkg::SatDivWidth'(delta)
                * rhc_pkg::SatDivWidth'(rhc_pkg::FullScale);

      // top dividend bits are already below the divisor since the quotient fits
      data_in.hue.rem  = hue_div[rhc_pkg::HueDivWidth-1:rhc_pkg::DivSteps];
      data_in.hue.bits = hue_div[rhc_pkg::DivSteps-1:0];
      // zero divisor only occurs with a zero dividend; dividing by one gives zero
      data_in.hue.divisor = (delta == '0) ? rhc_pkg::ChanWidth'(1) : delta;
      data_in.sat.rem  = rhc_pkg::ChanWidth'(sat_div[rhc_pkg::SatDivWidth-1:rhc_pkg::DivSteps]);
      data_in.sat.bits = sat_div[rhc_pkg::DivSteps-1:0];
      data_in.sat.divisor = (hi == '0) ? rhc_pkg::ChanWidth'(1) : hi;
      data_in.brightness  = hi;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rhc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module rhc_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  rhc_pkg::cell_data_type in_data,
   output logic                   out_valid,
   input  wire                    out_ready,
   output rhc_pkg::cell_data_type out_data
);

   logic                   valid_ff;
   rhc_pkg::cell_data_type data_ff;
   rhc_pkg::cell_data_type data_in;

   // one quotient bit for both hue and saturation per cell
   always_comb begin
      data_in            = in_data;
      data_in.hue        = rhc_pkg::div_step(in_data.hue);
      data_in.sat        = rhc_pkg::div_step(in_data.sat);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_hsv_converter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// RGB to HSV converter, one pixel per item.
// Input stream req_*: one RGB pixel per item, red in the low byte.
// Output stream rsp_*: hue in 1/64 degree, saturation (255 = 1.0) and value.
// Path from acceptance to rsp_tvalid: one stage
// finds max, min and the hue position and forms both dividends, then a row of
// 15 divider cells each produces one quotient bit of hue and of saturation.
// Throughput: one item per cycle while rsp_tready is high; each cell hands its
// item to the next when not stalled, and the last cell register holds the result.
// Stalls: each stage loads whenever it is empty or its successor takes its item,
// so bubbles are squeezed out and new pixels are still taken while a result waits
// on rsp_tready until the whole row is full.
// Reset clears all stage valid bits; the row is empty and req_tready is high
// right after reset.
// Grey pixels give hue 0; black pixels give hue 0 and saturation 0.

module rgb_to_hsv_converter_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata    // hue [14:0], saturation [22:15],
                                    // brightness [30:23], zero [31]
);

   logic                   valid_chain [rhc_pkg::DivSteps+1];
   logic                   ready_chain [rhc_pkg::DivSteps+1];
   rhc_pkg::cell_data_type data_chain  [rhc_pkg::DivSteps+1];

   rhc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (valid_chain[0]),
      .out_ready (ready_chain[0]),
      .out_data  (data_chain[0])
   );

   for (genvar i = 0; i < rhc_pkg::DivSteps; i++) begin : g_cell
      rhc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_data   (data_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_ready (ready_chain[i+1]),
         .out_data  (data_chain[i+1])
      );
   end

   assign ready_chain[rhc_pkg::DivSteps] = rsp_tready;
   assign rsp_tvalid = valid_chain[rhc_pkg::DivSteps];
   assign rsp_tdata  = {1'b0,
                        data_chain[rhc_pkg::DivSteps].brightness,
                        data_chain[rhc_pkg::DivSteps].sat.bits[rhc_pkg::ChanWidth-1:0],
                        data_chain[rhc_pkg::DivSteps].hue.bits};

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

   localparam int RandPixels = 1330;
   localparam int PauseAt    = 700;   // sender waits for the row to drain before this item
   localparam int HoldAfter  = 300;   // results seen before the long receiver hold
   localparam int HoldCycles = 120;
   localparam int QuietTail  = 250;   // last items run with no idling at all
   localparam int CycleLimit = 400000;
   localparam int MaxReports = 100;
   localparam int UnitsPerSixth = 3840;

   typedef struct packed {
      logic [rhc_pkg::HueWidth-1:0]  hue;
      logic [rhc_pkg::ChanWidth-1:0] saturation;
      logic [rhc_pkg::ChanWidth-1:0] brightness;
   } hsv_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // red [7:0], green [15:8], blue [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // hue [14:0], saturation [22:15], brightness [30:23]

   logic [23:0] pixel_q[$];
   hsv_type     hsv_q[$];
   int          pixel_total = 0;
   int          accepted    = 0;
   int          results     = 0;
   int          fail_cnt    = 0;
   int          report_cnt  = 0;
   logic        req_fire  = 1'b0;
   logic        sink_hold = 1'b0;

   rgb_to_hsv_converter_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic hsv_type rgb_to_hsv(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      hsv_type     res;
      int unsigned hi;
      int unsigned lo;
      int unsigned delta;
      int unsigned pos;
      hi    = (r > g) ? r : g;
      hi    = (hi > b) ? hi : b;
      lo    = (r < g) ? r : g;
      lo    = (lo < b) ? lo : b;
      delta = hi - lo;
      res.brightness = hi[7:0];
      res.saturation = (hi == 0) ? '0 : 8'((255 * delta) / hi);
      res.hue        = '0;
      if (delta != 0) begin
         // ties resolve red first, then green
         if (r == hi) begin
            pos = (g >= b) ? g - b : 6 * delta - (b - g);
         end else if (g == hi) begin
            pos = 2 * delta + b - r;
         end else begin
            pos = 4 * delta + r - g;
         end
         res.hue = 15'((UnitsPerSixth * pos) / delta);
      end
      return res;
   endfunction

   task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      pixel_q.push_back({b, g, r});
      pixel_total++;
   endtask

   // stimulus and end of run
   initial begin
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      // black, white, greys, primaries, ties, red wrap-around, bit patterns
      queue_pixel(8'd0, 8'd0, 8'd0);
      queue_pixel(8'd255, 8'd255, 8'd255);
      queue_pixel(8'd128, 8'd128, 8'd128);
      queue_pixel(8'd1, 8'd1, 8'd1);
      queue_pixel(8'd255, 8'd0, 8'd0);
      queue_pixel(8'd0, 8'd255, 8'd0);
      queue_pixel(8'd0, 8'd0, 8'd255);
      queue_pixel(8'd255, 8'd255, 8'd0);
      queue_pixel(8'd0, 8'd255, 8'd255);
      queue_pixel(8'd255, 8'd0, 8'd255);
      queue_pixel(8'd255, 8'd0, 8'd1);
      queue_pixel(8'd255, 8'd1, 8'd0);
      queue_pixel(8'd10, 8'd200, 8'd50);
      queue_pixel(8'd30, 8'd40, 8'd250);
      queue_pixel(8'd200, 8'd20, 8'd100);
      queue_pixel(8'd1, 8'd0, 8'd0);
      queue_pixel(8'd0, 8'd1, 8'd0);
      queue_pixel(8'd0, 8'd0, 8'd1);
      queue_pixel(8'd170, 8'd85, 8'd170);
      queue_pixel(8'd85, 8'd170, 8'd85);
      queue_pixel(8'd255, 8'd254, 8'd0);
      queue_pixel(8'd0, 8'd254, 8'd255);
      for (int i = 0; i < RandPixels; i++) begin
         r = 8'($urandom_range(0, 255));
         g = 8'($urandom_range(0, 255));
         b = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 7) == 0) begin
            r = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
            b = 8'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 11) == 0) begin
            g = r;
            b = r;
         end
         if ($urandom_range(0, 9) == 0) g = r;
         if ($urandom_range(0, 9) == 0) b = g;
         if ($urandom_range(0, 9) == 0) b = r;
         if ($urandom_range(0, 11) == 0) r = 8'd255;
         queue_pixel(r, g, b);
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (accepted != pixel_total || hsv_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("rgb_to_hsv_converter_top test passed");
      end else begin
         $display("rgb_to_hsv_converter_top test failed");
      end
      $finish;
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("%0t: timeout, %0d of %0d items accepted, %0d results", $time, accepted,
               pixel_total, results);
      $display("rgb_to_hsv_converter_top test failed");
      $finish;
   end

   // pixel driver
   int src_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (sink_hold) src_gap = 0;
         if (src_gap > 0) begin
            src_gap--;
            req_tvalid <= 1'b0;
         end else if (pixel_q.size() == 0 || (accepted == PauseAt && hsv_q.size() != 0)) begin
            req_tvalid <= 1'b0;
         end else begin
            req_tdata  <= pixel_q.pop_front();
            req_tvalid <= 1'b1;
            if (!sink_hold && accepted < pixel_total - QuietTail && $urandom_range(0, 5) == 0)
               src_gap = $urandom_range(1, 17);
         end
      end
   end

   // result receiver; one long hold lets the row fill and back up the input
   int sink_gap  = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
         sink_hold  <= (hold_left > 0);
      end else if (!hold_done && results >= HoldAfter) begin
         hold_done = 1;
         hold_left = HoldCycles;
         rsp_tready <= 1'b0;
         sink_hold  <= 1'b1;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (accepted < pixel_total - QuietTail && $urandom_range(0, 5) == 0)
            sink_gap = $urandom_range(1, 17);
      end
   end

   // monitor: predict on input acceptance, check on output acceptance
   always @(posedge clock) begin
      hsv_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            hsv_q.push_back(rgb_to_hsv(req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]));
            accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results++;
            if (hsv_q.size() == 0) begin
               fail_cnt++;
               if (report_cnt++ < MaxReports)
                  $display("%0t: unexpected item, expected none, got 0x%08h", $time, rsp_tdata);
            end else begin
               want = hsv_q.pop_front();
               if (rsp_tdata[14:0] !== want.hue || rsp_tdata[22:15] !== want.saturation ||
                   rsp_tdata[30:23] !== want.brightness || rsp_tdata[31] !== 1'b0) begin
                  fail_cnt++;
                  if (report_cnt++ < MaxReports)
                     $display({"%0t: item %0d expected h=%0d s=%0d v=%0d pad=0,",
                               " got h=%0d s=%0d v=%0d pad=%b"},
                              $time, results - 1, want.hue, want.saturation, want.brightness,
                              rsp_tdata[14:0], rsp_tdata[22:15], rsp_tdata[30:23], rsp_tdata[31]);
               end
            end
         end
      end
   end

endmodule
